// ===== design/jsesc_pkg.sv =====
// ============================================================================
// jsesc_pkg
// Shared types, character codes and small lookup functions for the JSON
// string escaper with UTF-8 checking.
// ============================================================================
package jsesc_pkg;

   // Character codes
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5c;
   localparam logic [7:0] CHAR_U      = 8'h75;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_F      = 8'h66;
   localparam logic [7:0] CHAR_D      = 8'h64;

   // Last position of a six-byte escape (\ufffd or \u00XX)
   localparam logic [2:0] ESC6_LAST = 3'd5;

   // What follows the run of replacement escapes in one job
   typedef enum logic [1:0] {
      TAIL_NONE = 2'd0,   // nothing
      TAIL_COPY = 2'd1,   // raw bytes copied through
      TAIL_ESC  = 2'd2,   // backslash then the byte
      TAIL_CTL  = 2'd3    // \u00XX
   } tail_kind_type;

   // Output work for one accepted input beat
   typedef struct packed {
      logic [2:0]       rep_cnt;     // number of \ufffd escapes, 0..4
      tail_kind_type    kind;
      logic [2:0]       copy_len;    // raw bytes for TAIL_COPY, 1..4
      logic [3:0][7:0]  copy_bytes;  // entry 0 is also the byte for ESC/CTL
      logic             last;        // item closes the buffer
      logic             has_out;     // job produces at least one beat
   } job_type;

   // Byte of the replacement escape at a given position
   function automatic logic [7:0] repl_char(input logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0:    ch = CHAR_BSLASH;
         3'd1:    ch = CHAR_U;
         3'd2:    ch = CHAR_F;
         3'd3:    ch = CHAR_F;
         3'd4:    ch = CHAR_F;
         default: ch = CHAR_D;
      endcase
      return ch;
   endfunction

   // Lowercase hex digit
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) ch = CHAR_ZERO + {4'h0, nib};
      else             ch = 8'h57 + {4'h0, nib};
      return ch;
   endfunction

endpackage

// ===== design/jsesc_decode.sv =====
// ============================================================================
// jsesc_decode
// Holds the pending UTF-8 sequence and turns each accepted byte into an
// output job: a run of replacement escapes followed by an optional tail.
// ============================================================================
module jsesc_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              last_in_buffer,
   output jsesc_pkg::job_type job
);
   import jsesc_pkg::*;

   localparam logic [20:0] CP_MIN2    = 21'h000080;
   localparam logic [20:0] CP_MIN3    = 21'h000800;
   localparam logic [20:0] CP_MIN4    = 21'h010000;
   localparam logic [20:0] CP_SURR_LO = 21'h00d800;
   localparam logic [20:0] CP_SURR_HI = 21'h00dfff;
   localparam logic [20:0] CP_MAX     = 21'h10ffff;

   // Pending sequence state
   logic [7:0]  held_ff [3];
   logic [7:0]  held_in [3];
   logic [1:0]  held_cnt_ff, held_cnt_in;
   logic [2:0]  seq_len_ff, seq_len_in;
   logic [20:0] cp_ff, cp_in;

   // Fresh-byte classification
   logic          f_repl, f_hold;
   tail_kind_type f_kind;
   logic [2:0]    f_len;
   logic [20:0]   f_acc;

   logic        is_cont, complete, bad;
   logic [2:0]  cnt_inc;
   logic [20:0] acc_ext;
   logic [1:0]  base;

   // Classify the byte as if nothing were held
   always_comb begin
      f_repl = 1'b0;
      f_hold = 1'b0;
      f_kind = TAIL_NONE;
      f_len  = 3'd0;
      f_acc  = '0;
      if (data_byte inside {CHAR_QUOTE, CHAR_BSLASH}) begin
         f_kind = TAIL_ESC;
      end else if (data_byte inside {[8'h00:8'h1f]}) begin
         f_kind = TAIL_CTL;
      end else if (!data_byte[7]) begin
         f_kind = TAIL_COPY;
      end else if (data_byte[7:5] == 3'b110) begin
         f_len = 3'd2;
         f_acc = {16'd0, data_byte[4:0]};
      end else if (data_byte[7:4] == 4'b1110) begin
         f_len = 3'd3;
         f_acc = {17'd0, data_byte[3:0]};
      end else if (data_byte[7:3] == 5'b11110) begin
         f_len = 3'd4;
         f_acc = {18'd0, data_byte[2:0]};
      end else begin
         f_repl = 1'b1;
      end
      // a lead byte on the buffer's last beat can never complete
      if (f_len != 3'd0) begin
         if (last_in_buffer) f_repl = 1'b1;
         else                f_hold = 1'b1;
      end
   end

   // Continuation handling and code point checks
   assign is_cont  = (data_byte[7:6] == 2'b10);
   assign acc_ext  = {cp_ff[14:0], data_byte[5:0]};
   assign cnt_inc  = {1'b0, held_cnt_ff} + 3'd1;
   assign complete = (cnt_inc >= seq_len_ff);
   assign bad      = ((seq_len_ff == 3'd2) && (acc_ext < CP_MIN2)) ||
                     ((seq_len_ff == 3'd3) && (acc_ext < CP_MIN3)) ||
                     ((seq_len_ff == 3'd4) && (acc_ext < CP_MIN4)) ||
                     ((acc_ext >= CP_SURR_LO) && (acc_ext <= CP_SURR_HI)) ||
                     (acc_ext > CP_MAX);

   // Job build and next state
   always_comb begin
      held_in     = held_ff;
      held_cnt_in = held_cnt_ff;
      seq_len_in  = seq_len_ff;
      cp_in       = cp_ff;
      job.rep_cnt  = 3'd0;
      job.kind     = TAIL_NONE;
      job.copy_len = 3'd0;
      job.last     = last_in_buffer;
      base         = 2'd0;

      if (held_cnt_ff == 2'd0 || !is_cont) begin
         // held lead and continuation bytes (if any) each become \ufffd
         job.rep_cnt  = {1'b0, held_cnt_ff} + {2'b00, f_repl};
         job.kind     = f_kind;
         job.copy_len = (f_kind == TAIL_COPY) ? 3'd1 : 3'd0;
         held_cnt_in  = 2'd0;
         seq_len_in   = 3'd0;
         cp_in        = '0;
         if (f_hold) begin
            held_in[0]  = data_byte;
            held_cnt_in = 2'd1;
            seq_len_in  = f_len;
            cp_in       = f_acc;
         end
      end else if (complete) begin
         held_cnt_in = 2'd0;
         seq_len_in  = 3'd0;
         cp_in       = '0;
         if (bad) begin
            job.rep_cnt = cnt_inc;
         end else begin
            job.kind     = TAIL_COPY;
            job.copy_len = cnt_inc;
            base         = held_cnt_ff;
         end
      end else if (last_in_buffer) begin
         job.rep_cnt = cnt_inc;
         held_cnt_in = 2'd0;
         seq_len_in  = 3'd0;
         cp_in       = '0;
      end else begin
         if (held_cnt_ff == 2'd1) held_in[1] = data_byte;
         if (held_cnt_ff == 2'd2) held_in[2] = data_byte;
         held_cnt_in = cnt_inc[1:0];
         cp_in       = acc_ext;
      end

      // held bytes first, then the current byte
      job.copy_bytes[0] = (base > 2'd0) ? held_ff[0] : data_byte;
      job.copy_bytes[1] = (base > 2'd1) ? held_ff[1] : data_byte;
      job.copy_bytes[2] = (base > 2'd2) ? held_ff[2] : data_byte;
      job.copy_bytes[3] = data_byte;
      job.has_out = (job.rep_cnt != 3'd0) || (job.kind != TAIL_NONE);
   end

   // Sequence registers
   always_ff @(posedge clock) begin
      if (reset) begin
         held_cnt_ff <= 2'd0;
         seq_len_ff  <= 3'd0;
         cp_ff       <= '0;
      end else if (accept) begin
         held_cnt_ff <= held_cnt_in;
         seq_len_ff  <= seq_len_in;
         cp_ff       <= cp_in;
      end
   end

   // Held bytes: payload only
   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule

// ===== design/jsesc_emit.sv =====
// ============================================================================
// jsesc_emit
// Job register and byte sequencer: walks one job a beat per cycle into the
// result register while it is not stalled.
// ============================================================================
module jsesc_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  jsesc_pkg::job_type job,
   output logic               req_stall,
   output logic               busy,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_end_of_item,
   output logic               rsp_end_of_buffer
);
   import jsesc_pkg::*;

   job_type     job_ff;
   logic        job_valid_ff;
   logic [2:0]  pos_ff;
   logic        rsp_valid_ff;
   logic [7:0]  out_byte_ff;
   logic        eoi_ff, eob_ff;

   logic [7:0]  cur_byte;
   logic        unit_end, job_end, adv;

   // Current byte of the job
   always_comb begin
      cur_byte = job_ff.copy_bytes[0];
      unit_end = 1'b1;
      job_end  = 1'b1;
      if (job_ff.rep_cnt != 3'd0) begin
         cur_byte = repl_char(pos_ff);
         unit_end = (pos_ff == ESC6_LAST);
         job_end  = unit_end && (job_ff.rep_cnt == 3'd1) && (job_ff.kind == TAIL_NONE);
      end else begin
         case (job_ff.kind)
            TAIL_COPY: begin
               cur_byte = job_ff.copy_bytes[pos_ff[1:0]];
               unit_end = (pos_ff == (job_ff.copy_len - 3'd1));
            end
            TAIL_ESC: begin
               cur_byte = (pos_ff == 3'd0) ? CHAR_BSLASH : job_ff.copy_bytes[0];
               unit_end = (pos_ff == 3'd1);
            end
            TAIL_CTL: begin
               case (pos_ff)
                  3'd0:    cur_byte = CHAR_BSLASH;
                  3'd1:    cur_byte = CHAR_U;
                  3'd2:    cur_byte = CHAR_ZERO;
                  3'd3:    cur_byte = CHAR_ZERO;
                  3'd4:    cur_byte = hex_char(job_ff.copy_bytes[0][7:4]);
                  default: cur_byte = hex_char(job_ff.copy_bytes[0][3:0]);
               endcase
               unit_end = (pos_ff == ESC6_LAST);
            end
            default: begin
               cur_byte = job_ff.copy_bytes[0];
               unit_end = 1'b1;
            end
         endcase
         job_end = unit_end;
      end
   end

   // Handshake: a beat moves when the result register is free
   assign adv       = job_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = job_valid_ff && !(adv && job_end);
   assign busy      = job_valid_ff;

   // Job control
   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         pos_ff       <= 3'd0;
      end else if (load) begin
         job_valid_ff <= job.has_out;
         pos_ff       <= 3'd0;
      end else if (adv) begin
         if (job_end)       job_valid_ff <= 1'b0;
         if (unit_end)      pos_ff       <= 3'd0;
         else               pos_ff       <= pos_ff + 3'd1;
      end
   end

   // Job payload; the replacement count steps down in place
   always_ff @(posedge clock) begin
      if (load) begin
         job_ff <= job;
      end else if (adv && unit_end && (job_ff.rep_cnt != 3'd0)) begin
         job_ff.rep_cnt <= job_ff.rep_cnt - 3'd1;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_byte_ff <= cur_byte;
         eoi_ff      <= job_end;
         eob_ff      <= job_end && job_ff.last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_end_of_item   = eoi_ff;
   assign rsp_end_of_buffer = eob_ff;

endmodule

// ===== design/json_string_escape_utf8_check_top.sv =====
// The first result beat of an accepted input beat passes through the job
// register, then the result register. Throughput: one result beat per
// cycle while rsp_stall is low; an item makes 0 to 24 beats, and the next
// item is taken in the cycle its predecessor's last beat moves. Plain ASCII
// therefore streams at one item per cycle while rsp_stall is low. Reset
// (synchronous) drops any held UTF-8 sequence and empties the job and result registers.
// ============================================================================
// json_string_escape_utf8_check_top
// JSON string escaper with UTF-8 validation: decoder with sequence state,
// then a byte sequencer feeding the result register.
// ============================================================================
module json_string_escape_utf8_check_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_in_buffer,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_end_of_item,
   output logic       rsp_end_of_buffer
);
   import jsesc_pkg::*;

   job_type job;
   logic    accept;
   logic    busy;

   assign accept = req_valid && !req_stall;

   // Sequence state and job build
   jsesc_decode u_decode (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .data_byte      (req_data_byte),
      .last_in_buffer (req_last_in_buffer),
      .job            (job)
   );

   // Byte sequencer and result register
   jsesc_emit u_emit (
      .clock             (clock),
      .reset             (reset),
      .load              (accept),
      .job               (job),
      .req_stall         (req_stall),
      .busy              (busy),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_of_item   (rsp_end_of_item),
      .rsp_end_of_buffer (rsp_end_of_buffer)
   );

`ifndef SYNTHESIS
   // end of buffer only on the closing beat of an item
   a_eob_on_eoi: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_buffer |-> rsp_end_of_item)
      else $error("end of buffer without end of item");

   // a beat marked last always produces output
   a_last_has_output: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_in_buffer |=> busy)
      else $error("last beat produced no job");

   // nothing is offered straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !busy)
      else $error("output not empty after reset");
`endif

endmodule
